// ===== rtl/uer_pkg.sv =====
package uer_pkg;

    localparam int SPEED_W     = 16;
    localparam int TRIG_W      = 8;
    localparam int DIST_W      = 17;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd34300;
    localparam logic [TRIG_W-1:0]  TRIG_RESET  = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED         = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 4'd1;

    // pulse widths at or above 2^SPAN_W us saturate for any nonzero speed
    localparam int SPAN_W = 38;
    localparam int PROD_W = SPEED_W + SPAN_W;

    // speed * width >= 131072 * 2000000 saturates the distance
    localparam logic [PROD_W-1:0] SAT_LIMIT = 54'd262144000000;

    // 2000000 = 2^7 * 15625; the /15625 is a reciprocal multiply
    localparam int PRE_SHIFT   = 7;
    localparam int X_W         = 31;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 44;
    localparam logic [RECIP_W-1:0] RECIP = 31'd1125899907;
    localparam int MUL_W = X_W + RECIP_W;

    localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [SPEED_W-1:0] speed_cms;
        logic [TRIG_W-1:0]  trig_width;
    } t_cfg;

    // one tick as handed from the front to the back
    typedef struct packed {
        logic              trig;
        logic              dist_en;
        logic              span_ovf;
        logic [SPAN_W-1:0] span;
    } t_op;

endpackage

// ===== rtl/uer_ifs.sv =====
interface uer_item_if;
    logic valid;
    logic ready;
    logic fire_request;
    logic echo_level;

    modport source (output valid, output fire_request, output echo_level, input ready);
    modport sink   (input valid, input fire_request, input echo_level, output ready);
endinterface

interface uer_result_if;
    logic        valid;
    logic        ready;
    logic        trig_level;
    logic        distance_valid;
    logic [16:0] distance_cm;

    modport source (output valid, output trig_level, output distance_valid,
                    output distance_cm, input ready);
    modport sink   (input valid, input trig_level, input distance_valid,
                    input distance_cm, output ready);
endinterface

interface uer_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/uer_front.sv =====
module uer_front #(
    parameter int TIME_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uer_pkg::t_cfg i_cfg,
    uer_item_if.sink      i_item,
    input  logic          i_full,
    output logic          o_push,
    output uer_pkg::t_op  o_word
);
    import uer_pkg::*;

    logic                  r_prev_echo;
    logic [TIME_WIDTH-1:0] r_tick;
    logic [TIME_WIDTH-1:0] r_start;
    logic [TRIG_W-1:0]     r_remaining;

    logic [TRIG_W-1:0]     n_remaining;
    logic                  accept;
    logic                  rise;
    logic                  fall;
    logic [TIME_WIDTH-1:0] span_full;
    logic [TRIG_W-1:0]     rem_eff;

    assign i_item.ready = !i_full;
    assign accept       = i_item.valid && !i_full;
    assign rise         = i_item.echo_level && !r_prev_echo;
    assign fall         = !i_item.echo_level && r_prev_echo;
    assign span_full    = r_tick - r_start;

    always_comb begin
        rem_eff     = i_item.fire_request ? i_cfg.trig_width : r_remaining;
        n_remaining = (rem_eff != '0) ? rem_eff - TRIG_W'(1) : rem_eff;
    end

    generate
        if (TIME_WIDTH > SPAN_W) begin : g_clamp
            assign o_word.span_ovf = |span_full[TIME_WIDTH-1:SPAN_W];
            assign o_word.span     = span_full[SPAN_W-1:0];
        end else begin : g_extend
            assign o_word.span_ovf = 1'b0;
            assign o_word.span     = SPAN_W'(span_full);
        end
    endgenerate

    assign o_word.trig    = (rem_eff != '0);
    // falling edge with end not below start (no counter wrap in between)
    assign o_word.dist_en = fall && (r_tick >= r_start);
    assign o_push         = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_echo <= 1'b0;
            r_tick      <= '0;
            r_start     <= '0;
            r_remaining <= '0;
        end else if (accept) begin
            r_prev_echo <= i_item.echo_level;
            r_tick      <= r_tick + TIME_WIDTH'(1);
            r_remaining <= n_remaining;
            if (rise) begin
                r_start <= r_tick;
            end
        end
    end

    a_trig_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_item.fire_request && r_remaining != '0)
            |=> (r_remaining == $past(r_remaining) - TRIG_W'(1)))
        else $error("trigger countdown skipped a tick");

endmodule

// ===== rtl/uer_queue.sv =====
module uer_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  uer_pkg::t_op i_word,
    input  logic         i_pop,
    output uer_pkg::t_op o_word,
    output logic         o_full,
    output logic         o_empty
);
    import uer_pkg::*;

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("word popped from empty queue");

endmodule

// ===== rtl/uer_back.sv =====
module uer_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uer_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  uer_pkg::t_op  i_word,
    output logic          o_pop,
    uer_result_if.source  o_result
);
    import uer_pkg::*;

    // stage 1: speed * span
    logic              r_s1_valid;
    logic              r_s1_trig;
    logic              r_s1_dist;
    logic              r_s1_ovf;
    logic              r_s1_speed_nz;
    logic [PROD_W-1:0] r_s1_prod;
    // stage 2: reciprocal multiply
    logic              r_s2_valid;
    logic              r_s2_trig;
    logic              r_s2_dist;
    logic              r_s2_sat;
    logic [MUL_W-1:0]  r_s2_mul;
    // output word
    logic              r_out_valid;
    logic              r_out_trig;
    logic              r_out_dvalid;
    logic [DIST_W-1:0] r_out_dist;
    logic [DIST_W-1:0] r_smooth;

    logic              advance;
    logic [X_W-1:0]    pre_q;
    logic [DIST_W-1:0] raw_dist;
    logic [DIST_W:0]   diff;
    logic [DIST_W:0]   diff_adj;
    logic [DIST_W:0]   half;
    logic [DIST_W-1:0] n_smooth;

    assign advance = !r_out_valid || o_result.ready;
    assign o_pop   = advance && i_valid;
    assign pre_q   = r_s1_prod[PRE_SHIFT+X_W-1:PRE_SHIFT];

    always_comb begin
        raw_dist = r_s2_sat ? DIST_MAX : r_s2_mul[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];
        diff     = {1'b0, raw_dist} - {1'b0, r_smooth};
        // halve toward zero: bias negative values by one before the shift
        diff_adj = diff + {{DIST_W{1'b0}}, diff[DIST_W]};
        half     = {diff_adj[DIST_W], diff_adj[DIST_W:1]};
        if (r_smooth == '0) begin
            n_smooth = raw_dist;
        end else begin
            n_smooth = r_smooth + half[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_trig     <= i_word.trig;
            r_s1_dist     <= i_word.dist_en;
            r_s1_ovf      <= i_word.span_ovf;
            r_s1_speed_nz <= (i_cfg.speed_cms != '0);
            r_s1_prod     <= PROD_W'(i_cfg.speed_cms) * PROD_W'(i_word.span);

            r_s2_trig <= r_s1_trig;
            r_s2_dist <= r_s1_dist;
            r_s2_sat  <= (r_s1_ovf && r_s1_speed_nz) || (r_s1_prod >= SAT_LIMIT);
            r_s2_mul  <= MUL_W'(pre_q) * MUL_W'(RECIP);

            r_out_trig   <= r_s2_trig;
            r_out_dvalid <= r_s2_dist;
            r_out_dist   <= r_s2_dist ? n_smooth : r_smooth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_smooth    <= '0;
        end else if (advance) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            if (r_s2_valid && r_s2_dist) begin
                r_smooth <= n_smooth;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.trig_level     = r_out_trig;
    assign o_result.distance_valid = r_out_dvalid;
    assign o_result.distance_cm    = r_out_dist;

    a_smooth_only_on_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_smooth) |-> $past(advance && r_s2_valid && r_s2_dist))
        else $error("smoothed distance moved without a new measurement");

    a_new_distance_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dvalid) |-> (r_out_dist == r_smooth))
        else $error("reported distance differs from smoothed value");

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Channel    Modport   Word
// i_item     sink      fire_request, echo_level (one microsecond tick)
// o_result   source    trig_level, distance_valid, distance_cm
// i_cfg      sink      index, data (0: speed of sound cm/s, 1: trigger width ticks)
//
// One tick per clock sustained while o_result.ready holds; a result passes through
// the queue, the two multiplier stages and the output register.
// The front takes a tick whenever the 4-word queue has room; the back stalls
// as one pipeline on o_result.ready. i_cfg is always ready.
// i_rst_n is synchronous: counters, edge state, smoothing and queue clear,
// config returns to 34300 cm/s and 10 ticks.
module ultrasonic_echo_ranger #(
    parameter int TIME_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    uer_item_if.sink     i_item,
    uer_result_if.source o_result,
    uer_cfg_if.sink      i_cfg
);
    import uer_pkg::*;

    t_cfg r_cfg;
    t_op  push_word;
    t_op  pop_word;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_cms  <= SPEED_RESET;
            r_cfg.trig_width <= TRIG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SPEED:         r_cfg.speed_cms  <= i_cfg.data[SPEED_W-1:0];
                CFG_TRIGGER_WIDTH: r_cfg.trig_width <= i_cfg.data[TRIG_W-1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    uer_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_word  (push_word)
    );

    uer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_word  (pop_word),
        .o_full  (full),
        .o_empty (empty)
    );

    uer_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (!empty),
        .i_word   (pop_word),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

// ===== sim/tb_ultrasonic_echo_ranger.sv =====
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger;
    import uer_pkg::*;

    // time base narrower than SPAN_W
    localparam int TIME_W = 16;
    localparam longint unsigned HALF_US_PER_S = 64'd2000000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd15;
    localparam int DRAIN_CYCLES = 10;
    localparam longint TIMEOUT_NS = 64'd40_000_000;

    typedef struct packed {
        logic              trig;
        logic              dvalid;
        logic [DIST_W-1:0] dist_cm;
    } t_range_word;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  fire;
        logic                  echo;
        logic [15:0]           reps;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        t_range_word           exp_w;
    } t_row;

    localparam int N_DIRECTED = 24;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        // out of reset: 34300 cm/s, 10-tick trigger
        '{ROW_TICK, 1'b0, 1'b0, 16'd1, CFG_UNMAPPED, 16'd0, 1'b1, '{1'b0, 1'b0, 17'd0}},
        '{ROW_TICK, 1'b1, 1'b0, 16'd1, CFG_UNMAPPED, 16'd0, 1'b1, '{1'b1, 1'b0, 17'd0}},
        '{ROW_TICK, 1'b0, 1'b1, 16'd1, CFG_UNMAPPED, 16'd0, 1'b1, '{1'b1, 1'b0, 17'd0}},
        '{ROW_TICK, 1'b0, 1'b0, 16'd1, CFG_UNMAPPED, 16'd0, 1'b1, '{1'b1, 1'b1, 17'd0}},
        '{ROW_CFG, 1'b0, 1'b0, 16'd0, CFG_SPEED, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, 1'b0, 1'b0, 16'd0, CFG_TRIGGER_WIDTH, 16'd1, 1'b0, '0},
        '{ROW_TICK, 1'b1, 1'b1, 16'd1, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 1'b1, 16'd90, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 1'b0, 16'd1, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        // shorter pulse: odd difference truncates toward zero
        '{ROW_TICK, 1'b0, 1'b1, 16'd40, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 1'b0, 16'd1, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 1'b1, 16'd100, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 1'b0, 16'd2, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        // fire held: pulse restarts every tick, then runs out
        '{ROW_CFG, 1'b0, 1'b0, 16'd0, CFG_TRIGGER_WIDTH, 16'd8, 1'b0, '0},
        '{ROW_TICK, 1'b1, 1'b0, 16'd10, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b1, 1'b0, 16'd1, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 1'b0, 16'd10, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        // zero width: fire gives no pulse
        '{ROW_CFG, 1'b0, 1'b0, 16'd0, CFG_TRIGGER_WIDTH, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b1, 1'b0, 16'd3, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        // unknown index is dropped; upper data bits of the width are dropped
        '{ROW_CFG, 1'b0, 1'b0, 16'd0, CFG_UNMAPPED, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, 1'b0, 1'b0, 16'd0, CFG_TRIGGER_WIDTH, 16'hAB05, 1'b0, '0},
        '{ROW_CFG, 1'b0, 1'b0, 16'd0, CFG_SPEED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b1, 1'b1, 16'd10, CFG_UNMAPPED, 16'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 1'b0, 16'd1, CFG_UNMAPPED, 16'd0, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    uer_item_if   item_if();
    uer_result_if res_if();
    uer_cfg_if    cfg_if();

    ultrasonic_echo_ranger #(
        .TIME_WIDTH(TIME_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(res_if),
        .i_cfg   (cfg_if)
    );

    // ranger state as predicted
    logic [SPEED_W-1:0] p_speed      = SPEED_RESET;
    logic [TRIG_W-1:0]  p_trig_width = TRIG_RESET;
    logic               p_prev_echo  = 1'b0;
    logic [TIME_W-1:0]  p_ticks      = '0;
    logic [TIME_W-1:0]  p_start      = '0;
    logic [TIME_W-1:0]  p_end        = '0;
    logic [DIST_W-1:0]  p_smooth     = '0;
    logic [TRIG_W-1:0]  p_trig_left  = '0;

    t_range_word range_due[$];
    t_range_word row_word;
    logic        row_typed = 1'b0;
    logic        tx_idle_on = 1'b1;
    logic        rx_stall_on = 1'b1;
    int unsigned ticks_sent = 0;
    int unsigned dist_reports = 0;
    int          err_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic ranger_step(input logic fire, input logic echo, output t_range_word w);
        logic [TIME_W-1:0] now;
        longint unsigned   raw;
        longint            s;
        now = p_ticks;
        w.dvalid = 1'b0;
        if (fire) begin
            p_trig_left = p_trig_width;
        end
        w.trig = (p_trig_left != 0);
        if (p_trig_left != 0) begin
            p_trig_left = p_trig_left - 1'b1;
        end
        if (echo && !p_prev_echo) begin
            p_start = now;
        end else if (!echo && p_prev_echo) begin
            p_end = now;
            // a wrapped counter leaves the distance alone
            if (p_end >= p_start) begin
                raw = p_speed;
                raw = raw * (p_end - p_start) / HALF_US_PER_S;
                if (raw > DIST_MAX) begin
                    raw = DIST_MAX;
                end
                if (p_smooth == 0) begin
                    p_smooth = raw[DIST_W-1:0];
                end else begin
                    s = p_smooth;
                    s = s + (longint'(raw) - s) / 2;
                    p_smooth = s[DIST_W-1:0];
                end
                w.dvalid = 1'b1;
            end
        end
        p_prev_echo = echo;
        p_ticks = now + 1'b1;
        w.dist_cm = p_smooth;
    endtask

    always @(posedge i_clk) begin
        t_range_word pred;
        t_range_word got;
        t_range_word want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == CFG_SPEED) begin
                    p_speed = cfg_if.data;
                end else if (cfg_if.index == CFG_TRIGGER_WIDTH) begin
                    p_trig_width = cfg_if.data[TRIG_W-1:0];
                end
            end
            if (item_if.valid && item_if.ready) begin
                ranger_step(item_if.fire_request, item_if.echo_level, pred);
                range_due.push_back(row_typed ? row_word : pred);
                ticks_sent++;
                if (pred.dvalid) begin
                    dist_reports++;
                end
            end
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.trig_level, res_if.distance_valid, res_if.distance_cm};
                if (range_due.size() == 0) begin
                    $error("unexpected result word: trig %0d valid %0d dist %0d",
                           got.trig, got.dvalid, got.dist_cm);
                    err_cnt++;
                end else begin
                    want = range_due.pop_front();
                    if (got.trig !== want.trig) begin
                        $error("trig_level: expected %0d, got %0d", want.trig, got.trig);
                        err_cnt++;
                    end
                    if (got.dvalid !== want.dvalid) begin
                        $error("distance_valid: expected %0d, got %0d",
                               want.dvalid, got.dvalid);
                        err_cnt++;
                    end
                    if (got.dist_cm !== want.dist_cm) begin
                        $error("distance_cm: expected %0d, got %0d",
                               want.dist_cm, got.dist_cm);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_stall_on && $urandom_range(0, 7) == 0) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_tick(input logic fire, input logic echo);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            item_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        item_if.valid        = 1'b1;
        item_if.fire_request = fire;
        item_if.echo_level   = echo;
        do @(posedge i_clk); while (!item_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input logic fire, input logic echo, input int unsigned n);
        repeat (n) drive_tick(fire, echo);
    endtask

    task automatic wait_drained();
        item_if.valid = 1'b0;
        wait (range_due.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic wr_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    initial begin
        int          r;
        int          ph;
        int unsigned kind;
        int unsigned w;
        int unsigned items0;
        int unsigned meas0;
        logic [SPEED_W-1:0] speed;
        logic [TRIG_W-1:0]  width;

        i_rst_n              = 1'b0;
        item_if.valid        = 1'b0;
        item_if.fire_request = 1'b0;
        item_if.echo_level   = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_UNMAPPED;
        cfg_if.data          = '0;
        row_word             = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                wait_drained();
                wr_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                row_typed = DIRECTED[r].typed;
                row_word  = DIRECTED[r].exp_w;
                send_ticks(DIRECTED[r].fire, DIRECTED[r].echo, DIRECTED[r].reps);
                row_typed = 1'b0;
            end
        end

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    speed = 16'hFFFF;
                    width = 8'd255;
                end
                1: begin
                    speed = 16'd34300;
                    width = 8'd1;
                end
                2: begin
                    speed = SPEED_W'($urandom);
                    width = TRIG_W'($urandom_range(1, 255));
                end
                default: begin
                    speed = SPEED_W'($urandom_range(20000, 65535));
                    width = TRIG_W'($urandom_range(1, 255));
                end
            endcase
            wait_drained();
            wr_reg(CFG_SPEED, speed);
            wr_reg(CFG_TRIGGER_WIDTH, {8'($urandom), width});
            items0 = ticks_sent;
            meas0  = dist_reports;
            while (ticks_sent - items0 < 20 || dist_reports - meas0 < 2) begin
                tx_idle_on  = (ph != 3) && ($urandom_range(0, 3) != 0);
                rx_stall_on = (ph != 3) && ($urandom_range(0, 3) != 0);
                kind = $urandom_range(0, 9);
                if (kind <= 5) begin
                    // fire, quiet gap, echo pulse, back low
                    drive_tick(1'b1, 1'b0);
                    send_ticks(1'b0, 1'b0, $urandom_range(0, 3));
                    w = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                    : $urandom_range(1, 20);
                    send_ticks(1'b0, 1'b1, w);
                    send_ticks(1'b0, 1'b0, $urandom_range(1, 3));
                end else if (kind <= 7) begin
                    repeat ($urandom_range(1, 10)) begin
                        drive_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                end else if (kind == 8) begin
                    // echo with no trigger before it
                    send_ticks(1'b0, 1'b1, $urandom_range(1, 3));
                    drive_tick(1'($urandom_range(0, 1)), 1'b0);
                end else begin
                    // second fire soon after the first, inside its pulse when the width is long enough
                    drive_tick(1'b1, 1'b0);
                    send_ticks(1'b0, 1'b0, $urandom_range(1, 5));
                    drive_tick(1'b1, 1'b1);
                    send_ticks(1'b0, 1'b1, $urandom_range(1, 20));
                    drive_tick(1'b0, 1'b0);
                end
                if (ph != 3 && $urandom_range(0, 19) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
